FILE: src/dfec_pkg.sv
// Package for the diagnostic frame escape codec.
// Holds the framing byte constants and the plan word passed from the front end to the
// back end. No dependencies.
package dfec_pkg;

   // Framing and escape bytes.
   localparam logic [7:0] FLAG_BYTE     = 8'h7E;
   localparam logic [7:0] ESC_BYTE      = 8'h7D;
   localparam logic [7:0] FLAG_ESC_CODE = 8'h5E;
   localparam logic [7:0] ESC_ESC_CODE  = 8'h5D;
   localparam logic [7:0] ESC_XOR       = 8'h20;
   localparam logic [7:0] ESC_COUNT_MAX = 8'hFF;

   // Most output bytes that one input word can produce.
   localparam int unsigned MAX_RUN = 4;

   // Mode codes.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // The output bytes that one input word produces, ready to be sent.
   typedef struct packed {
      logic [MAX_RUN-1:0][7:0]       run_bytes;
      logic [$clog2(MAX_RUN)-1:0]    last_idx;
      logic                          frame_end;
      logic                          dangling;
      logic [7:0]                    esc_count;
   } plan_type;

   // Write side of the plan queue.
   typedef struct packed {
      logic     push;
      plan_type plan;
   } queue_wr_type;

   // Read side of the plan queue.
   typedef struct packed {
      logic     not_empty;
      plan_type plan;
   } queue_rd_type;

endpackage

FILE: src/dfec_front.sv
// Front end of the frame escape codec: accepts input words, keeps the decode escape
// state and turns each word into a plan of up to four output bytes. Uses dfec_pkg.
module dfec_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  logic                  req_last_byte,
   input  logic                  queue_full,
   output dfec_pkg::queue_wr_type queue_wr
);
   import dfec_pkg::*;

   logic       pending_ff, pending_in;
   logic [7:0] count_ff, count_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the word and build its output run.
   always_comb begin
      logic [2:0] n;
      logic       pend;
      logic [7:0] cnt;
      plan_type   p;

      n    = '0;
      pend = req_first_byte ? 1'b0 : pending_ff;
      cnt  = req_first_byte ? 8'd0 : count_ff;
      p    = '0;

      if (req_mode == MODE_ENCODE) begin
         if (req_first_byte) begin
            p.run_bytes[n[1:0]] = FLAG_BYTE;
            n = n + 3'd1;
         end
         if (req_data_byte == FLAG_BYTE || req_data_byte == ESC_BYTE) begin
            p.run_bytes[n[1:0]] = ESC_BYTE;
            n = n + 3'd1;
            p.run_bytes[n[1:0]] = (req_data_byte == FLAG_BYTE) ? FLAG_ESC_CODE
                                                               : ESC_ESC_CODE;
            n = n + 3'd1;
         end else begin
            p.run_bytes[n[1:0]] = req_data_byte;
            n = n + 3'd1;
         end
         if (req_last_byte) begin
            p.run_bytes[n[1:0]] = FLAG_BYTE;
            n = n + 3'd1;
            p.frame_end = 1'b1;
         end
      end else begin
         if (pend) begin
            pend = 1'b0;
            p.run_bytes[0] = req_data_byte ^ ESC_XOR;
            n = 3'd1;
         end else if (req_data_byte == FLAG_BYTE || req_data_byte == ESC_BYTE) begin
            pend = 1'b1;
            if (cnt != ESC_COUNT_MAX) begin
               cnt = cnt + 8'd1;
            end
         end else begin
            p.run_bytes[0] = req_data_byte;
            n = 3'd1;
         end
         if (req_last_byte) begin
            // A frame that ends on an escape yields one flagged, empty byte.
            if (n == 3'd0) begin
               p.run_bytes[0] = 8'd0;
               p.dangling     = 1'b1;
               n = 3'd1;
            end
            p.frame_end = 1'b1;
            p.esc_count = cnt;
            pend = 1'b0;
            cnt  = 8'd0;
         end
      end

      p.last_idx      = n[1:0] - 2'd1;
      pending_in      = pend;
      count_in        = cnt;
      queue_wr.plan   = p;
      queue_wr.push   = accept && (n != 3'd0);
   end

   // Decode escape state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= 8'd0;
      end else if (accept) begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

endmodule

FILE: src/dfec_queue.sv
// Short plan queue between the front and back ends of the frame escape codec.
// Register-based, one push and one pop per cycle. Uses dfec_pkg.
module dfec_queue #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dfec_pkg::queue_wr_type queue_wr,
   input  logic                   pop,
   output logic                   full,
   output dfec_pkg::queue_rd_type queue_rd
);
   import dfec_pkg::*;

   localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   plan_type            entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full               = (cnt_ff == CntW'(QUEUE_DEPTH));
   assign queue_rd.not_empty = (cnt_ff != '0);
   assign queue_rd.plan      = entry_ff[rd_ptr_ff];
   assign do_push            = queue_wr.push && !full;
   assign do_pop             = pop && queue_rd.not_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.plan;
      end
   end

endmodule

FILE: src/dfec_back.sv
// Back end of the frame escape codec: steps through the head plan one byte per cycle,
// while the receiver keeps up, into the output register. Uses dfec_pkg.
module dfec_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dfec_pkg::queue_rd_type queue_rd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_frame_end,
   output logic                   rsp_dangling_escape,
   output logic [7:0]             rsp_escapes_removed
);
   import dfec_pkg::*;

   logic                       valid_ff;
   logic [$clog2(MAX_RUN)-1:0] idx_ff, idx_in;
   logic [7:0]                 byte_ff, esc_ff;
   logic                       run_last_ff, frame_end_ff, dangling_ff;
   logic                       load, at_last;

   // Load a new word whenever the output register is free or being drained.
   assign load    = queue_rd.not_empty && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == queue_rd.plan.last_idx);
   assign pop     = load && at_last;
   assign idx_in  = at_last ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Output payload; frame results go only on the last byte of a run.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff      <= queue_rd.plan.run_bytes[idx_ff];
         run_last_ff  <= at_last;
         frame_end_ff <= at_last && queue_rd.plan.frame_end;
         dangling_ff  <= at_last && queue_rd.plan.dangling;
         esc_ff       <= at_last ? queue_rd.plan.esc_count : 8'd0;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_run_last        = run_last_ff;
   assign rsp_frame_end       = frame_end_ff;
   assign rsp_dangling_escape = dangling_ff;
   assign rsp_escapes_removed = esc_ff;

endmodule

FILE: src/diag_frame_escape_codec.sv
// HDLC-style byte-stuffing codec for diagnostic frames. In encode mode each input word
// yields one to four output words (opening flag, stuffed byte pair, closing flag); in
// decode mode it yields zero or one. The front end takes one input word per cycle while
// the plan queue has room; the back end sends one output word per cycle while the receiver
// is ready. Plans wait in a QUEUE_DEPTH-entry queue, so input and output stall
// independently.
module diag_frame_escape_codec #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end,
   output logic       rsp_dangling_escape,
   output logic [7:0] rsp_escapes_removed
);
   import dfec_pkg::*;

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         pop;

   dfec_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .queue_full     (queue_full),
      .queue_wr       (queue_wr)
   );

   dfec_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .full     (queue_full),
      .queue_rd (queue_rd)
   );

   dfec_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_rd            (queue_rd),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_dangling_escape (rsp_dangling_escape),
      .rsp_escapes_removed (rsp_escapes_removed)
   );

endmodule

FILE: test/frame_stuffing_checker.sv
// Checker for the diagnostic frame escape codec: watches both channels, predicts the
// stuffed or unstuffed output words, and compares them in order.
// Depends on dfec_pkg for the framing byte constants and mode codes.
module frame_stuffing_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_frame_end,
   input  logic        rsp_dangling_escape,
   input  logic [7:0]  rsp_escapes_removed,
   output int unsigned fail_count,
   output int unsigned words_pending
);
   import dfec_pkg::*;

   // One output word as the block should produce it.
   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
      logic       dangling;
      logic [7:0] escapes;
   } coded_word_type;

   coded_word_type expected_words[$];

   // Decoder state: an escape is waiting for its data byte, and escapes seen this frame.
   logic       unstuff_pending;
   logic [7:0] unstuff_count;

   function automatic coded_word_type plain_word(input logic [7:0] b);
      coded_word_type w;
      w.out_byte  = b;
      w.run_last  = 1'b0;
      w.frame_end = 1'b0;
      w.dangling  = 1'b0;
      w.escapes   = 8'h00;
      return w;
   endfunction

   // Work out the output words that one accepted input word causes and queue them.
   task automatic stuff_or_unstuff(input logic m, input logic [7:0] d, input logic f,
                                   input logic l);
      coded_word_type run [MAX_RUN];
      int             n;
      n = 0;
      if (f) begin
         unstuff_pending = 1'b0;
         unstuff_count   = 8'h00;
      end
      if (m == MODE_ENCODE) begin
         if (f) begin
            run[n] = plain_word(FLAG_BYTE);
            n++;
         end
         if (d == FLAG_BYTE) begin
            run[n] = plain_word(ESC_BYTE);
            run[n+1] = plain_word(FLAG_ESC_CODE);
            n += 2;
         end else if (d == ESC_BYTE) begin
            run[n] = plain_word(ESC_BYTE);
            run[n+1] = plain_word(ESC_ESC_CODE);
            n += 2;
         end else begin
            run[n] = plain_word(d);
            n++;
         end
         if (l) begin
            run[n] = plain_word(FLAG_BYTE);
            run[n].frame_end = 1'b1;
            n++;
         end
      end else begin
         // The byte after an escape is always data, even if it is an escape byte itself.
         if (unstuff_pending) begin
            unstuff_pending = 1'b0;
            run[n] = plain_word(d ^ ESC_XOR);
            n++;
         end else if (d == FLAG_BYTE || d == ESC_BYTE) begin
            unstuff_pending = 1'b1;
            if (unstuff_count != ESC_COUNT_MAX) begin
               unstuff_count++;
            end
         end else begin
            run[n] = plain_word(d);
            n++;
         end
         // A frame that ends on an escape gives a single flagged word with no data.
         if (l) begin
            if (n == 0) begin
               run[n] = plain_word(8'h00);
               run[n].dangling = 1'b1;
               n++;
            end
            run[n-1].frame_end = 1'b1;
            run[n-1].escapes   = unstuff_count;
            unstuff_pending = 1'b0;
            unstuff_count   = 8'h00;
         end
      end
      if (n > 0) begin
         run[n-1].run_last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_words.push_back(run[i]);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Input words are predicted before output words are matched in the same cycle.
   always @(posedge clock) begin : watch
      coded_word_type w;
      if (reset) begin
         expected_words.delete();
         unstuff_pending = 1'b0;
         unstuff_count   = 8'h00;
         fail_count      = 0;
      end else begin
         if (req_valid && req_ready) begin
            stuff_or_unstuff(req_mode, req_data_byte, req_first_byte, req_last_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("output word %0h arrived with none expected", rsp_out_byte);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               check_field("out_byte", 32'(w.out_byte), 32'(rsp_out_byte));
               check_field("run_last", 32'(w.run_last), 32'(rsp_run_last));
               check_field("frame_end", 32'(w.frame_end), 32'(rsp_frame_end));
               check_field("dangling_escape", 32'(w.dangling), 32'(rsp_dangling_escape));
               check_field("escapes_removed", 32'(w.escapes), 32'(rsp_escapes_removed));
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

FILE: test/diag_frame_escape_codec_test.sv
// Top of the frame escape codec testbench: drives encode and decode frames into the
// block, stalls its output, and reports the verdict from frame_stuffing_checker.
// Depends on dfec_pkg, diag_frame_escape_codec and frame_stuffing_checker.
module diag_frame_escape_codec_test;
   import dfec_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_data_byte;
   logic        req_first_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_frame_end;
   logic        rsp_dangling_escape;
   logic [7:0]  rsp_escapes_removed;
   int unsigned fail_count;
   int unsigned words_pending;

   // Sender pacing and the request for a long output stall.
   int unsigned sent_count = 0;
   int unsigned burst_left = 0;
   int unsigned no_gap_left = 0;
   bit          start_hold = 1'b0;

   diag_frame_escape_codec dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_data_byte       (req_data_byte),
      .req_first_byte      (req_first_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_dangling_escape (rsp_dangling_escape),
      .rsp_escapes_removed (rsp_escapes_removed)
   );

   frame_stuffing_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_data_byte       (req_data_byte),
      .req_first_byte      (req_first_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_dangling_escape (rsp_dangling_escape),
      .rsp_escapes_removed (rsp_escapes_removed),
      .fail_count          (fail_count),
      .words_pending       (words_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offer one word and hold it until accepted; between bursts the sender goes quiet.
   task automatic send_word(input logic m, input logic [7:0] d, input logic f,
                            input logic l);
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_data_byte  <= d;
      req_first_byte <= f;
      req_last_byte  <= l;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_count++;
      if (no_gap_left > 0) begin
         no_gap_left--;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Stop offering words until every predicted output word has come out.
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Data bytes lean toward the flag and escape bytes and the byte extremes.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1:    return FLAG_BYTE;
         2, 3:    return ESC_BYTE;
         4:       return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One marked frame in a single mode, now and then with a word of the other mode.
   task automatic send_random_frame();
      logic m;
      int   len;
      m = 1'($urandom_range(0, 1));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
         send_word(($urandom_range(0, 19) == 0) ? ~m : m, pick_byte(), k == 0,
                   k == len - 1);
      end
   endtask

   // Output side: the stall style is picked anew at random, and a requested hold
   // keeps the output blocked long enough for the block to fill up.
   initial begin : receiver
      int unsigned hold_left;
      int unsigned style;
      int unsigned style_left;
      int unsigned cyc;
      hold_left  = 0;
      style      = 0;
      style_left = 0;
      cyc        = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (start_hold) begin
            start_hold = 1'b0;
            hold_left  = 80;
         end
         if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(20, 60);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 2) != 0);
               2:       rsp_ready <= ((cyc % 5) >= 2);
               default: rsp_ready <= ((cyc % 4) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      bit held;
      bit drained;
      held    = 1'b0;
      drained = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_ENCODE;
      req_data_byte  <= 8'h00;
      req_first_byte <= 1'b0;
      req_last_byte  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Encode: one-byte frames carrying each stuffed byte and a plain byte, then a three-byte frame.
      send_word(MODE_ENCODE, FLAG_BYTE, 1'b1, 1'b1);
      send_word(MODE_ENCODE, ESC_BYTE, 1'b1, 1'b1);
      send_word(MODE_ENCODE, 8'h00, 1'b1, 1'b1);
      send_word(MODE_ENCODE, 8'hFF, 1'b1, 1'b0);
      send_word(MODE_ENCODE, 8'h41, 1'b0, 1'b0);
      send_word(MODE_ENCODE, FLAG_BYTE, 1'b0, 1'b1);

      // Decode: both escape bytes, an escaped escape byte, and a closing data byte.
      send_word(MODE_DECODE, 8'h41, 1'b1, 1'b0);
      send_word(MODE_DECODE, ESC_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, ESC_ESC_CODE, 1'b0, 1'b0);
      send_word(MODE_DECODE, FLAG_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, FLAG_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, 8'h00, 1'b0, 1'b0);
      send_word(MODE_DECODE, 8'hFF, 1'b0, 1'b1);

      // Decode frames that end on a dangling escape, one of them a single byte.
      send_word(MODE_DECODE, FLAG_BYTE, 1'b1, 1'b1);
      send_word(MODE_DECODE, 8'h10, 1'b1, 1'b0);
      send_word(MODE_DECODE, ESC_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, ESC_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, FLAG_BYTE, 1'b0, 1'b1);

      // Escaped byte that closes the frame.
      send_word(MODE_DECODE, ESC_BYTE, 1'b1, 1'b0);
      send_word(MODE_DECODE, ESC_XOR, 1'b0, 1'b1);

      // An encode word inside a decode frame leaves the pending escape alone.
      send_word(MODE_DECODE, FLAG_BYTE, 1'b1, 1'b0);
      send_word(MODE_ENCODE, 8'h55, 1'b0, 1'b0);
      send_word(MODE_DECODE, FLAG_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, 8'h80, 1'b0, 1'b1);

      // Bytes outside any marked frame.
      send_word(MODE_DECODE, ESC_BYTE, 1'b0, 1'b0);
      send_word(MODE_DECODE, 8'h33, 1'b0, 1'b0);
      send_word(MODE_ENCODE, FLAG_BYTE, 1'b0, 1'b0);

      // Random part: mostly whole frames, some loose words with random marks.
      while (sent_count < 250) begin
         if (!held && sent_count >= 120) begin
            held        = 1'b1;
            start_hold  = 1'b1;
            no_gap_left = 24;
         end
         if (!drained && sent_count >= 200) begin
            drained = 1'b1;
            drain_outputs();
         end
         if ($urandom_range(0, 6) == 0) begin
            send_word(1'($urandom_range(0, 1)), pick_byte(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            send_random_frame();
         end
      end

      // One long decode frame with many escapes, ending on a dangling escape.
      for (int k = 0; k < 40; k++) begin
         send_word(MODE_DECODE, ($urandom_range(0, 1) == 1) ? FLAG_BYTE : ESC_BYTE,
                   k == 0, 1'b0);
         send_word(MODE_DECODE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_word(MODE_DECODE, ESC_BYTE, 1'b0, 1'b1);

      drain_outputs();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(8 * 200000);
      $display("Verification failed");
      $finish;
   end

endmodule
